// ===== hdl/record_ring_buffer_top_assert.svh =====
// ----------------------------------------------------------------------------
// record_ring_buffer_top_assert.svh
// assertion macros for the record ring buffer rtl, used by rrb_back
// ----------------------------------------------------------------------------
`ifndef RECORD_RING_BUFFER_TOP_ASSERT_SVH
`define RECORD_RING_BUFFER_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RRB_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("record ring buffer assertion failed");

// antecedent implies consequent in the same cycle
`define RRB_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("record ring buffer assertion failed");

`endif

// ===== hdl/rrb_pkg.sv =====
// ----------------------------------------------------------------------------
// rrb_pkg
// types, codes and helpers of the record ring buffer
// ----------------------------------------------------------------------------
package rrb_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int MAX_BYTES_DEF = 64;
    localparam int Q_DEPTH       = 2;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 3;
    localparam int FILL_W = 5;
    localparam int TOT_W  = 32;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FN_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_STOP = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NOP  = 2'd3;

    localparam logic [STAT_W-1:0] ST_BYTE      = 3'd0;
    localparam logic [STAT_W-1:0] ST_STORED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_REF_STOP  = 3'd2;
    localparam logic [STAT_W-1:0] ST_REF_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_ENDED     = 3'd5;
    localparam logic [STAT_W-1:0] ST_STOP_DONE = 3'd6;
    localparam logic [STAT_W-1:0] ST_TRUNC     = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd1;

    localparam logic [LEN_W-1:0] MAX_LEN_RST = 7'd64;
    localparam logic [LEN_W-1:0] WLEN_SAT    = 7'd127;

    typedef struct packed {
        logic [FUNC_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  want;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  count;
        logic              last;
        logic [LEN_W-1:0]  remaining;
        logic [FILL_W-1:0] fill;
        logic [TOT_W-1:0]  pushed;
        logic [TOT_W-1:0]  popped;
    } t_res;

    // zero acts as one, anything above cap acts as cap
    function automatic logic [LEN_W-1:0] f_clamp_len(input logic [LEN_W-1:0] v,
                                                     input logic [LEN_W-1:0] cap);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = 7'd1;
        end else if (v > cap) begin
            r = cap;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/rrb_front.sv =====
// ----------------------------------------------------------------------------
// rrb_front
// accepts input transactions, decodes the function and clamps the pop size
// ----------------------------------------------------------------------------
module rrb_front #(
    parameter int MAX_BYTES = rrb_pkg::MAX_BYTES_DEF
) (
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rrb_pkg::IN_TDATA_W-1:0]  i_data,   // data_in, want, pad
    input  logic [rrb_pkg::FUNC_W-1:0]      i_user,   // func
    input  logic                            i_last,
    input  logic                            i_q_ready,
    output logic                            o_q_push,
    output rrb_pkg::t_cmd                   o_cmd
);
    import rrb_pkg::*;

    localparam logic [LEN_W-1:0] CAP = LEN_W'(MAX_BYTES);

    assign o_ready  = i_q_ready;
    // no-op transactions are taken and dropped here
    assign o_q_push = i_valid && i_q_ready && (i_user != FN_NOP);

    always_comb begin
        o_cmd.kind = i_user;
        o_cmd.data = i_data[BYTE_W-1:0];
        o_cmd.last = i_last;
        o_cmd.want = f_clamp_len(i_data[BYTE_W+LEN_W-1:BYTE_W], CAP);
    end

endmodule

// ===== hdl/rrb_queue.sv =====
// ----------------------------------------------------------------------------
// rrb_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module rrb_queue #(
    parameter int DEPTH = rrb_pkg::Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rrb_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output rrb_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import rrb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/rrb_back.sv =====
// ----------------------------------------------------------------------------
// rrb_back
// executes queued commands against the slot ring and emits result transactions
// ----------------------------------------------------------------------------
`include "record_ring_buffer_top_assert.svh"

module rrb_back #(
    parameter int SLOTS     = rrb_pkg::SLOTS_DEF,
    parameter int MAX_BYTES = rrb_pkg::MAX_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [rrb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrb_pkg::LEN_W-1:0]      i_cfg_data,
    input  logic                           i_q_valid,
    input  rrb_pkg::t_cmd                  i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_res_valid,
    output rrb_pkg::t_res                  o_res,
    input  logic                           i_res_ready
);
    import rrb_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int HELD_W = $clog2(SLOTS + 1);
    localparam int DEPTH  = SLOTS * MAX_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OFS_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LEN   = 2'd1;
    localparam logic [1:0] S_BYTES = 2'd2;

    localparam logic [LEN_W-1:0]  CAP       = LEN_W'(MAX_BYTES);
    localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(MAX_BYTES);

    // ring state
    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_head, n_head, r_tail, n_tail;
    logic [HELD_W-1:0] r_held, n_held;
    logic [OFS_W-1:0]  r_ofs, n_ofs;
    logic [LEN_W-1:0]  r_wlen, n_wlen;
    logic              r_blocked, n_blocked;
    logic [TOT_W-1:0]  r_in_tot, n_in_tot, r_out_tot, n_out_tot;
    logic              r_policy;
    logic [LEN_W-1:0]  r_max_len;

    // pop sequencer
    logic [LEN_W-1:0]  r_want, n_want, r_k, n_k, r_n, n_n, r_left, n_left;
    logic [ADDR_W-1:0] r_base, n_base;

    // storage
    logic [BYTE_W-1:0] r_store [DEPTH];
    logic [LEN_W-1:0]  r_lens  [SLOTS];
    logic [BYTE_W-1:0] r_rd_data;
    logic [LEN_W-1:0]  r_len_rd;

    // read stage and output register
    logic              r_rp_valid, r_rp_mem, r_out_valid;
    t_res              r_rp, r_out;

    logic              out_free, move, stage_adv;
    logic              rp_load, rp_mem;
    t_res              rp_res;
    t_res              out_nxt;
    logic              st_we, st_re, len_we, len_re;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [SLOT_W-1:0] head_inc, tail_inc;
    logic [ADDR_W-1:0] tail_base, head_base;
    logic [LEN_W-1:0]  lim, wlen_inc, stored, len, ofs_ext, rem, cnt, k_inc;
    logic              drop;

    assign out_free  = !r_out_valid || i_res_ready;
    assign move      = r_rp_valid && out_free;
    assign stage_adv = !r_rp_valid || move;

    assign head_inc  = (r_head == SLOT_LAST) ? '0 : r_head + 1'b1;
    assign tail_inc  = (r_tail == SLOT_LAST) ? '0 : r_tail + 1'b1;
    assign tail_base = ADDR_W'(r_tail) * SLOT_SPAN;
    assign head_base = ADDR_W'(r_head) * SLOT_SPAN;
    assign lim       = f_clamp_len(r_max_len, CAP);
    assign wlen_inc  = (r_wlen != WLEN_SAT) ? r_wlen + 1'b1 : r_wlen;
    assign stored    = (wlen_inc < lim) ? wlen_inc : lim;
    assign drop      = (r_wlen == '0) && (r_held == HELD_FULL);
    assign len       = (r_len_rd > CAP) ? CAP : r_len_rd;
    assign ofs_ext   = LEN_W'(r_ofs);
    assign rem       = (ofs_ext < len) ? len - ofs_ext : '0;
    assign cnt       = (rem > r_want) ? r_want : rem;
    assign k_inc     = r_k + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_held    = r_held;
        n_ofs     = r_ofs;
        n_wlen    = r_wlen;
        n_blocked = r_blocked;
        n_in_tot  = r_in_tot;
        n_out_tot = r_out_tot;
        n_want    = r_want;
        n_k       = r_k;
        n_n       = r_n;
        n_left    = r_left;
        n_base    = r_base;
        o_q_pop   = 1'b0;
        rp_load   = 1'b0;
        rp_mem    = 1'b0;
        rp_res    = '0;
        st_we     = 1'b0;
        st_waddr  = tail_base + ADDR_W'(r_wlen);
        st_re     = 1'b0;
        st_raddr  = r_base + ADDR_W'(r_k);
        len_we    = 1'b0;
        len_re    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && stage_adv) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.kind)
                        FN_PUSH: begin
                            rp_load     = 1'b1;
                            rp_res.last = 1'b1;
                            if (r_blocked) begin
                                rp_res.status = ST_REF_STOP;
                            end else if (drop && r_policy) begin
                                rp_res.status = ST_REF_FULL;
                            end else begin
                                // overwrite policy frees the oldest record first
                                if (drop) begin
                                    n_head = head_inc;
                                    n_ofs  = '0;
                                end
                                n_held = r_held - HELD_W'(drop);
                                if (r_wlen < lim) begin
                                    st_we         = 1'b1;
                                    n_in_tot      = r_in_tot + 1'b1;
                                    rp_res.status = ST_STORED;
                                end else begin
                                    rp_res.status = ST_TRUNC;
                                end
                                if (i_q_cmd.last) begin
                                    if (wlen_inc > lim) begin
                                        rp_res.status = ST_TRUNC;
                                    end
                                    len_we = 1'b1;
                                    n_tail = tail_inc;
                                    n_held = r_held - HELD_W'(drop) + 1'b1;
                                    n_wlen = '0;
                                end else begin
                                    n_wlen = wlen_inc;
                                end
                                rp_res.count = stored;
                            end
                        end
                        FN_POP: begin
                            if (r_held == '0) begin
                                rp_load       = 1'b1;
                                rp_res.last   = 1'b1;
                                rp_res.status = r_blocked ? ST_ENDED : ST_EMPTY;
                            end else begin
                                len_re  = 1'b1;
                                n_want  = i_q_cmd.want;
                                n_state = S_LEN;
                            end
                        end
                        FN_STOP: begin
                            n_blocked     = 1'b1;
                            n_wlen        = '0;
                            rp_load       = 1'b1;
                            rp_res.last   = 1'b1;
                            rp_res.status = ST_STOP_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEN: begin
                if (stage_adv) begin
                    n_out_tot = r_out_tot + TOT_W'(cnt);
                    n_base    = head_base + ADDR_W'(r_ofs);
                    n_k       = '0;
                    n_n       = cnt;
                    n_left    = rem - cnt;
                    if (rem != cnt) begin
                        n_ofs = OFS_W'(ofs_ext + cnt);
                    end else begin
                        n_head = head_inc;
                        n_held = r_held - 1'b1;
                        n_ofs  = '0;
                    end
                    if (cnt == '0) begin
                        // only a corrupt length gets here
                        rp_load       = 1'b1;
                        rp_res.last   = 1'b1;
                        rp_res.status = ST_EMPTY;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_BYTES;
                    end
                end
            end
            S_BYTES: begin
                if (stage_adv) begin
                    st_re            = 1'b1;
                    rp_load          = 1'b1;
                    rp_mem           = 1'b1;
                    rp_res.status    = ST_BYTE;
                    rp_res.count     = k_inc;
                    rp_res.last      = (k_inc == r_n);
                    rp_res.remaining = r_left;
                    n_k              = k_inc;
                    if (k_inc == r_n) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        rp_res.fill   = FILL_W'(n_held);
        rp_res.pushed = n_in_tot;
        rp_res.popped = n_out_tot;
    end

    // the byte read lands together with its result in the read stage
    always_comb begin
        out_nxt      = r_rp;
        out_nxt.data = r_rp_mem ? r_rd_data : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_ofs       <= '0;
            r_wlen      <= '0;
            r_blocked   <= 1'b0;
            r_in_tot    <= '0;
            r_out_tot   <= '0;
            r_policy    <= 1'b0;
            r_max_len   <= MAX_LEN_RST;
            r_rp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_held    <= n_held;
            r_ofs     <= n_ofs;
            r_wlen    <= n_wlen;
            r_blocked <= n_blocked;
            r_in_tot  <= n_in_tot;
            r_out_tot <= n_out_tot;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FULL_POLICY: r_policy  <= i_cfg_data[0];
                    CFG_MAX_LEN:     r_max_len <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (rp_load) begin
                r_rp_valid <= 1'b1;
            end else if (move) begin
                r_rp_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_want <= n_want;
        r_k    <= n_k;
        r_n    <= n_n;
        r_left <= n_left;
        r_base <= n_base;
        if (rp_load) begin
            r_rp     <= rp_res;
            r_rp_mem <= rp_mem;
        end
        if (move) begin
            r_out <= out_nxt;
        end
    end

    // byte store and slot lengths, registered reads
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= i_q_cmd.data;
        end
        if (st_re) begin
            r_rd_data <= r_store[st_raddr];
        end
        if (len_we) begin
            r_lens[r_tail] <= stored;
        end
        if (len_re) begin
            r_len_rd <= r_lens[r_head];
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `RRB_ASSERT_HOLDS(a_held_max, r_held <= HELD_FULL)
    `RRB_ASSERT_IMPLIES(a_blocked_no_record, r_blocked, r_wlen == '0)
    `RRB_ASSERT_IMPLIES(a_bytes_in_range, r_state == S_BYTES, r_k < r_n)
    `RRB_ASSERT_IMPLIES(a_len_stage_empty, r_state == S_LEN, !r_rp_valid)

endmodule

// ===== hdl/record_ring_buffer_top.sv =====
// ----------------------------------------------------------------------------
// record_ring_buffer_top
// ring of fixed slots holding variable-length byte records
// ----------------------------------------------------------------------------
// usage:
// - s_axis carries one command per transaction: push one byte (tlast ends the
//   record), pop up to want bytes, or stop further pushes; tuser is the function
// - m_axis carries result transactions; a pop gives one per byte, or one if empty,
//   push and stop one each, no-op none; tlast marks a command's final result
// - i_cfg_* writes full_policy (index 0) and max_record_len (index 1), idle only
// - push, stop and empty pop results pass the command queue, the read stage and
//   the output register; a pop's bytes follow its slot length read, one byte per
//   cycle unless m_axis stalls; the executer takes one push or stop per cycle
//   unless stalled; a pop of n bytes holds it for a length read and n byte reads
// - a two-entry command queue sits between the input decoder and the executer,
//   so s_axis keeps accepting while m_axis is stalled until the queue fills;
//   a stalled result holds in the output register and nothing is dropped
// - reset empties the ring, clears totals and the stop flag and restores the
//   register defaults; store contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module record_ring_buffer_top #(
    parameter int SLOTS     = rrb_pkg::SLOTS_DEF,
    parameter int MAX_BYTES = rrb_pkg::MAX_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rrb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // data_in, want, pad
    input  logic [rrb_pkg::FUNC_W-1:0]      s_axis_tuser,   // func
    input  logic                            s_axis_tlast,   // push_last
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_out, count, remaining, fill, pushed_bytes, popped_bytes, pad
    output logic [rrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [rrb_pkg::STAT_W-1:0]      m_axis_tuser,   // status
    output logic                            m_axis_tlast,   // last
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rrb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rrb_pkg::LEN_W-1:0]       i_cfg_data
);
    import rrb_pkg::*;

    localparam int RES_BITS = BYTE_W + 2 * LEN_W + FILL_W + 2 * TOT_W;

    logic q_push, q_ready, q_valid, q_pop, res_valid;
    t_cmd f_cmd, q_cmd;
    t_res res;

    assign o_cfg_ready = 1'b1;

    rrb_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_cmd     (f_cmd)
    );

    rrb_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    rrb_back #(
        .SLOTS     (SLOTS),
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tuser  = res.status;
    assign m_axis_tlast  = res.last;
    assign m_axis_tdata  = {(OUT_TDATA_W - RES_BITS)'(0), res.popped, res.pushed,
                            res.fill, res.remaining, res.count, res.data};

endmodule
